FILE: hdl/nnd_pkg.sv
package nnd_pkg;

    localparam int CoordW = 16;
    localparam int DistSqW = 35;
    localparam int DistW = 17;
    localparam int IdxOutW = 6;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    typedef struct packed {
        logic             overflowed;
        logic             too_few;
        logic             last;
        logic [IdxOutW-1:0] index;
    } t_res_tag;

    function automatic logic [2*CoordW+1:0] axis_sq(input t_coord a, input t_coord b);
        logic signed [CoordW:0] d;
        logic [CoordW:0] m;
        begin
            d = {a[CoordW-1], a} - {b[CoordW-1], b};
            m = d[CoordW] ? (~d + 1'b1) : d;
            axis_sq = m * m;
        end
    endfunction

endpackage

FILE: hdl/nnd_isqrt.sv
module nnd_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nnd_pkg::DistSqW-1:0]   i_value,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [nnd_pkg::DistW-1:0]     o_root
);

    localparam int Steps = (nnd_pkg::DistSqW + 1) / 2;
    localparam int RemW = nnd_pkg::DistSqW + 2;

    logic [2*Steps-1:0]       r_val;
    logic [RemW-1:0]          r_rem;
    logic [Steps-1:0]         r_root;
    logic [$clog2(Steps+1)-1:0] r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [RemW-1:0] w_rem;
    logic [RemW-1:0] w_trial;

    assign w_rem   = {r_rem[RemW-3:0], r_val[2*Steps-1 -: 2]};
    assign w_trial = {{(RemW-Steps-2){1'b0}}, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= $bits(r_cnt)'(Steps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == $bits(r_cnt)'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= (2*Steps)'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[2*Steps-3:0], 2'b00};
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {r_root[Steps-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {r_root[Steps-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root[nnd_pkg::DistW-1:0];

endmodule

FILE: hdl/nearest_neighbor_distances.sv
// Load: one request per cycle, no result until a request with tlast arrives.
// Search: per point, a read of the point, N pair reads, a square root and an
// output step.
// Results leave through a one-entry output register; loading stalls during a run.
// Synchronous active-low reset clears count, overflow flag and control; the
// point store is not cleared and only entries of the current set are read.
module nearest_neighbor_distances #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // nearest_distance, point_index
    output logic        m_axis_tlast,   // last_result
    output logic [1:0]  m_axis_tuser    // too_few_points, overflowed
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_RDI   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SQRT  = 6'b001000,
        S_OUT   = 6'b010000,
        S_FEW   = 6'b100000
    } t_state;

    t_state r_state;

    nnd_pkg::t_point r_mem [MAX_POINTS];
    nnd_pkg::t_point r_rd;
    nnd_pkg::t_point r_pi;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [AW-1:0] r_i;
    logic [CW-1:0] r_j;      // address issued
    logic          r_rd_v;
    logic [AW-1:0] r_rd_j;
    logic          r_have;
    logic [nnd_pkg::DistSqW-1:0] r_best;

    logic                    r_ovalid;
    logic [nnd_pkg::DistW-1:0] r_odist;
    nnd_pkg::t_res_tag       r_otag;

    logic w_s_acc;
    logic w_wr;
    logic [AW-1:0] w_raddr;
    logic w_rden;
    logic [nnd_pkg::DistSqW-1:0] w_d;
    logic w_sq_start;
    logic w_sq_busy;
    logic w_sq_done;
    logic [nnd_pkg::DistW-1:0] w_root;
    logic w_emit;

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_wr = w_s_acc && (r_count < CW'(MAX_POINTS));
    assign w_emit = (r_state == S_OUT || r_state == S_FEW) && (!r_ovalid || m_axis_tready);

    always_comb begin
        w_rden  = 1'b0;
        w_raddr = r_i;
        if (r_state == S_RDI) begin
            w_rden = 1'b1;
        end else if (r_state == S_SCAN && r_j < r_count) begin
            w_rden  = 1'b1;
            w_raddr = r_j[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        if (w_rden) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    assign w_d = nnd_pkg::DistSqW'(nnd_pkg::axis_sq(r_pi.x, r_rd.x))
               + nnd_pkg::DistSqW'(nnd_pkg::axis_sq(r_pi.y, r_rd.y))
               + nnd_pkg::DistSqW'(nnd_pkg::axis_sq(r_pi.z, r_rd.z));

    assign w_sq_start = (r_state == S_SCAN) && (r_j >= r_count) && !r_rd_v && !w_sq_busy;

    nnd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (r_best),
        .o_busy  (w_sq_busy),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDI) begin
            r_have <= 1'b0;
        end else if (r_state == S_SCAN && r_rd_v && r_rd_j != r_i) begin
            r_have <= 1'b1;
            if (!r_have || w_d < r_best) begin
                r_best <= w_d;
            end
        end
        if (r_state == S_SCAN && r_j == '0) begin
            r_pi <= r_rd;
        end
        r_rd_j <= w_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_rd_v   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_rd_v <= (r_state == S_SCAN) && w_rden;
            case (r_state)
                S_LOAD: begin
                    if (w_s_acc) begin
                        if (w_wr) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_i <= '0;
                            if ((w_wr ? r_count + 1'b1 : r_count) < CW'(2)) begin
                                r_state <= S_FEW;
                            end else begin
                                r_state <= S_RDI;
                            end
                        end
                    end
                end
                S_RDI: begin
                    r_j     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_rden) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (w_sq_start) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_emit) begin
                        r_odist           <= w_root;
                        r_otag.index      <= nnd_pkg::IdxOutW'(r_i);
                        r_otag.last       <= (CW'(r_i) + 1'b1 == r_count);
                        r_otag.too_few    <= 1'b0;
                        r_otag.overflowed <= r_ovf;
                        if (CW'(r_i) + 1'b1 == r_count) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RDI;
                        end
                    end
                end
                S_FEW: begin
                    if (w_emit) begin
                        r_odist           <= '0;
                        r_otag.index      <= '0;
                        r_otag.last       <= 1'b1;
                        r_otag.too_few    <= 1'b1;
                        r_otag.overflowed <= r_ovf;
                        r_count           <= '0;
                        r_ovf             <= 1'b0;
                        r_state           <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_otag.index, r_odist};
    assign m_axis_tlast  = r_otag.last;
    assign m_axis_tuser  = {r_otag.overflowed, r_otag.too_few};

endmodule
